[sv/scg_pkg.sv]
// ----------------------------------------------------------------------------
// scg_pkg
// Types, codes and constants shared by the solar charge gate modules.
// ----------------------------------------------------------------------------
`default_nettype none

package scg_pkg;

    localparam int SAMPLE_COUNT_BITS_DEF = 8;

    localparam int TEMP_W    = 12;
    localparam int THRESH_W  = 11;
    localparam int MV_W      = 16;
    localparam int CONFIRM_W = 8;
    localparam int CFG_IDX_W = 3;
    localparam int CFG_DAT_W = 16;

    localparam logic signed [TEMP_W-1:0] TEMP_FLOOR = -12'sd400;
    localparam logic signed [TEMP_W-1:0] TEMP_CEIL  = 12'sd850;

    localparam logic signed [THRESH_W-1:0] START_MIN_RST = 11'sd0;
    localparam logic signed [THRESH_W-1:0] START_MAX_RST = 11'sd450;
    localparam logic signed [THRESH_W-1:0] STOP_MIN_RST  = -11'sd50;
    localparam logic signed [THRESH_W-1:0] STOP_MAX_RST  = 11'sd500;
    localparam logic [MV_W-1:0]            PANEL_START_RST = 16'd5500;
    localparam logic [MV_W-1:0]            PANEL_STOP_RST  = 16'd4500;
    localparam logic [CONFIRM_W-1:0]       START_CONF_RST  = 8'd3;
    localparam logic [CONFIRM_W-1:0]       STOP_CONF_RST   = 8'd3;

    typedef enum logic [2:0] {
        MODE_WAIT_SENSORS  = 3'd0,
        MODE_WAIT_TEMP     = 3'd1,
        MODE_DAYLIGHT_WAIT = 3'd2,
        MODE_PROBE         = 3'd3,
        MODE_CHARGING      = 3'd4
    } t_mode;

    typedef enum logic [2:0] {
        WAIT_SENSOR   = 3'd0,
        WAIT_TEMP     = 3'd1,
        WAIT_DAYLIGHT = 3'd2,
        WAIT_SECOND   = 3'd3,
        WAIT_PROBE    = 3'd4,
        WAIT_CHECK    = 3'd5
    } t_wait;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_START_MIN_TEMP = 3'd0,
        REG_START_MAX_TEMP = 3'd1,
        REG_STOP_MIN_TEMP  = 3'd2,
        REG_STOP_MAX_TEMP  = 3'd3,
        REG_PANEL_START_MV = 3'd4,
        REG_PANEL_STOP_MV  = 3'd5,
        REG_START_CONFIRM  = 3'd6,
        REG_STOP_CONFIRM   = 3'd7
    } t_reg_idx;

    typedef struct packed {
        t_reg_idx             index;
        logic [CFG_DAT_W-1:0] value;
    } t_cfg_wr;

    typedef struct packed {
        logic signed [THRESH_W-1:0] start_min_temp;
        logic signed [THRESH_W-1:0] start_max_temp;
        logic signed [THRESH_W-1:0] stop_min_temp;
        logic signed [THRESH_W-1:0] stop_max_temp;
        logic [MV_W-1:0]            panel_start_mv;
        logic [MV_W-1:0]            panel_stop_mv;
        logic [CONFIRM_W-1:0]       start_confirm_count;
        logic [CONFIRM_W-1:0]       stop_confirm_count;
    } t_cfg;

    typedef struct packed {
        logic                     sensors_ok;
        logic signed [TEMP_W-1:0] temperature_tenths;
        logic [MV_W-1:0]          panel_mv;
    } t_in_item;

    typedef struct packed {
        logic  panel_connect;
        t_mode charge_state;
        t_wait wait_kind;
    } t_res_item;

endpackage

`default_nettype wire

[sv/scg_stream_if.sv]
// ----------------------------------------------------------------------------
// scg_stream_if
// Valid/ready channel carrying one payload item per handshake.
// ----------------------------------------------------------------------------
`default_nettype none

interface scg_stream_if #(
    parameter type T = logic
) ();
    logic valid;
    logic ready;
    T     data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

`default_nettype wire

[sv/solar_charge_gate_fsm.sv]
// ----------------------------------------------------------------------------
// solar_charge_gate_fsm
// Solar panel charge gate: per-tick temperature and panel voltage checks that
// drive the panel switch, report the charge state and the next wait interval.
// ----------------------------------------------------------------------------
// Channel  Dir  Payload     Accepted when
// i_cfg    in   t_cfg_wr    i_cfg.valid & i_cfg.ready (ready tied high)
// i_item   in   t_in_item   i_item.valid & i_item.ready
// o_res    out  t_res_item  o_res.valid & o_res.ready
//
// One item per cycle sustained while o_res.ready stays high; two registers (input
// register, result register), with the state machine logic between them.
// Synchronous active-low reset: mode wait-sensors, counters zero, switch open,
// registers at their defaults.
// A stalled result holds the result register; the input register still takes
// one more item, then ready drops until the result is taken.
// ----------------------------------------------------------------------------
`default_nettype none

module solar_charge_gate_fsm
    import scg_pkg::*;
#(
    parameter int SAMPLE_COUNT_BITS = SAMPLE_COUNT_BITS_DEF
) (
    input  wire logic    i_clk,
    input  wire logic    i_rst_n,
    scg_stream_if.sink   i_cfg,
    scg_stream_if.sink   i_item,
    scg_stream_if.source o_res
);

    t_cfg      cfg;
    t_res_item fsm_res;
    logic      fire;

    logic      r_s1_valid;
    t_in_item  r_s1_item;
    logic      r_out_valid;
    t_res_item r_out;

    scg_cfg_regs u_cfg_regs (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cfg   (i_cfg),
        .o_cfg   (cfg)
    );

    scg_fsm #(
        .SAMPLE_COUNT_BITS (SAMPLE_COUNT_BITS)
    ) u_fsm (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cfg   (cfg),
        .i_fire  (fire),
        .i_item  (r_s1_item),
        .o_res   (fsm_res)
    );

    assign fire         = r_s1_valid && (!r_out_valid || o_res.ready);
    assign i_item.ready = !r_s1_valid || fire;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else if (i_item.ready) begin
            r_s1_valid <= i_item.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_item.valid && i_item.ready) begin
            r_s1_item <= i_item.data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (fire) begin
            r_out_valid <= 1'b1;
        end else if (o_res.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (fire) begin
            r_out <= fsm_res;
        end
    end

    assign o_res.valid = r_out_valid;
    assign o_res.data  = r_out;

    a_connect_only_hot: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_res.valid && o_res.data.panel_connect) |->
        (o_res.data.charge_state == MODE_PROBE || o_res.data.charge_state == MODE_CHARGING))
        else $error("panel connected outside probe/charging");

    a_sensor_wait: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_res.valid |->
        ((o_res.data.charge_state == MODE_WAIT_SENSORS) == (o_res.data.wait_kind == WAIT_SENSOR)))
        else $error("wait-sensors state and sensor retry code disagree");

    a_probe_entry: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_res.valid && o_res.data.wait_kind == WAIT_PROBE) |->
        (o_res.data.charge_state == MODE_PROBE && o_res.data.panel_connect))
        else $error("probe delay without probe state and closed switch");

    a_reset_empty: assert property (@(posedge i_clk)
        $past(!i_rst_n) |-> (!o_res.valid && i_item.ready))
        else $error("pipeline not empty after reset");

endmodule

`default_nettype wire

[sv/scg_cfg_regs.sv]
// ----------------------------------------------------------------------------
// scg_cfg_regs
// Configuration register file: thresholds and confirm counts.
// ----------------------------------------------------------------------------
`default_nettype none

module scg_cfg_regs
    import scg_pkg::*;
(
    input  wire logic    i_clk,
    input  wire logic    i_rst_n,
    scg_stream_if.sink   i_cfg,
    output t_cfg         o_cfg
);

    t_cfg r_cfg;

    assign i_cfg.ready = 1'b1;
    assign o_cfg       = r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.start_min_temp      <= START_MIN_RST;
            r_cfg.start_max_temp      <= START_MAX_RST;
            r_cfg.stop_min_temp       <= STOP_MIN_RST;
            r_cfg.stop_max_temp       <= STOP_MAX_RST;
            r_cfg.panel_start_mv      <= PANEL_START_RST;
            r_cfg.panel_stop_mv       <= PANEL_STOP_RST;
            r_cfg.start_confirm_count <= START_CONF_RST;
            r_cfg.stop_confirm_count  <= STOP_CONF_RST;
        end else if (i_cfg.valid) begin
            unique case (i_cfg.data.index)
                REG_START_MIN_TEMP: r_cfg.start_min_temp <= i_cfg.data.value[THRESH_W-1:0];
                REG_START_MAX_TEMP: r_cfg.start_max_temp <= i_cfg.data.value[THRESH_W-1:0];
                REG_STOP_MIN_TEMP:  r_cfg.stop_min_temp  <= i_cfg.data.value[THRESH_W-1:0];
                REG_STOP_MAX_TEMP:  r_cfg.stop_max_temp  <= i_cfg.data.value[THRESH_W-1:0];
                REG_PANEL_START_MV: r_cfg.panel_start_mv <= i_cfg.data.value[MV_W-1:0];
                REG_PANEL_STOP_MV:  r_cfg.panel_stop_mv  <= i_cfg.data.value[MV_W-1:0];
                REG_START_CONFIRM: begin
                    r_cfg.start_confirm_count <= i_cfg.data.value[CONFIRM_W-1:0];
                end
                REG_STOP_CONFIRM: begin
                    r_cfg.stop_confirm_count <= i_cfg.data.value[CONFIRM_W-1:0];
                end
                default: ;
            endcase
        end
    end

endmodule

`default_nettype wire

[sv/scg_fsm.sv]
// ----------------------------------------------------------------------------
// scg_fsm
// Charge gate state machine: temperature windows, sun confirm counters,
// panel switch. Updates once per item.
// ----------------------------------------------------------------------------
`default_nettype none

module scg_fsm
    import scg_pkg::*;
#(
    parameter int SAMPLE_COUNT_BITS = SAMPLE_COUNT_BITS_DEF
) (
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    input  t_cfg      i_cfg,
    input  wire logic i_fire,
    input  t_in_item  i_item,
    output t_res_item o_res
);

    localparam int CMP_W = (SAMPLE_COUNT_BITS > CONFIRM_W) ? SAMPLE_COUNT_BITS : CONFIRM_W;
    localparam logic [SAMPLE_COUNT_BITS-1:0] CNT_MAX = '1;

    t_mode                        r_mode, n_mode;
    logic                         r_switch, n_switch;
    logic [SAMPLE_COUNT_BITS-1:0] r_start_cnt, n_start_cnt;
    logic [SAMPLE_COUNT_BITS-1:0] r_stop_cnt, n_stop_cnt;
    t_wait                        wait_code;

    logic signed [TEMP_W-1:0]     t;
    logic signed [TEMP_W-1:0]     start_min_x, start_max_x, stop_min_x, stop_max_x;
    logic                         in_range;
    logic                         start_window;
    logic                         stop_trip;
    logic                         hot_mode;
    logic [SAMPLE_COUNT_BITS-1:0] start_bump, stop_bump;
    logic                         start_done, stop_done;

    assign t        = i_item.temperature_tenths;
    assign in_range = i_item.sensors_ok && (t >= TEMP_FLOOR) && (t <= TEMP_CEIL);
    assign hot_mode = (r_mode == MODE_PROBE) || (r_mode == MODE_CHARGING);

    assign start_min_x = TEMP_W'(i_cfg.start_min_temp);
    assign start_max_x = TEMP_W'(i_cfg.start_max_temp);
    assign stop_min_x  = TEMP_W'(i_cfg.stop_min_temp);
    assign stop_max_x  = TEMP_W'(i_cfg.stop_max_temp);

    assign start_window = (t >= start_min_x) && (t <= start_max_x);
    assign stop_trip    = (t <= stop_min_x) || (t >= stop_max_x);

    // saturating sample counters
    assign start_bump = (r_start_cnt == CNT_MAX) ? r_start_cnt : r_start_cnt + 1'b1;
    assign stop_bump  = (r_stop_cnt == CNT_MAX) ? r_stop_cnt : r_stop_cnt + 1'b1;
    assign start_done = !(CMP_W'(start_bump) < CMP_W'(i_cfg.start_confirm_count));
    assign stop_done  = !(CMP_W'(stop_bump) < CMP_W'(i_cfg.stop_confirm_count));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode      <= MODE_WAIT_SENSORS;
            r_switch    <= 1'b0;
            r_start_cnt <= '0;
            r_stop_cnt  <= '0;
        end else if (i_fire) begin
            r_mode      <= n_mode;
            r_switch    <= n_switch;
            r_start_cnt <= n_start_cnt;
            r_stop_cnt  <= n_stop_cnt;
        end
    end

    always_comb begin
        n_mode      = r_mode;
        n_switch    = r_switch;
        n_start_cnt = r_start_cnt;
        n_stop_cnt  = r_stop_cnt;
        wait_code   = WAIT_SENSOR;
        if (!in_range) begin
            n_switch  = 1'b0;
            n_mode    = MODE_WAIT_SENSORS;
            wait_code = WAIT_SENSOR;
        end else if (hot_mode ? stop_trip : !start_window) begin
            n_switch  = 1'b0;
            n_mode    = MODE_WAIT_TEMP;
            wait_code = WAIT_TEMP;
        end else begin
            unique case (r_mode)
                MODE_WAIT_SENSORS, MODE_WAIT_TEMP: begin
                    n_switch  = 1'b0;
                    n_mode    = MODE_DAYLIGHT_WAIT;
                    wait_code = WAIT_DAYLIGHT;
                end
                MODE_DAYLIGHT_WAIT: begin
                    if (i_item.panel_mv < i_cfg.panel_start_mv) begin
                        n_start_cnt = '0;
                        wait_code   = WAIT_DAYLIGHT;
                    end else if (!start_done) begin
                        n_start_cnt = start_bump;
                        wait_code   = WAIT_SECOND;
                    end else begin
                        n_switch  = 1'b1;
                        n_mode    = MODE_PROBE;
                        wait_code = WAIT_PROBE;
                    end
                end
                MODE_PROBE: begin
                    if (i_item.panel_mv < i_cfg.panel_stop_mv) begin
                        n_switch  = 1'b0;
                        n_mode    = MODE_DAYLIGHT_WAIT;
                        wait_code = WAIT_DAYLIGHT;
                    end else begin
                        n_mode    = MODE_CHARGING;
                        wait_code = WAIT_CHECK;
                    end
                end
                MODE_CHARGING: begin
                    if (i_item.panel_mv >= i_cfg.panel_stop_mv) begin
                        n_stop_cnt = '0;
                        wait_code  = WAIT_CHECK;
                    end else if (!stop_done) begin
                        n_stop_cnt = stop_bump;
                        wait_code  = WAIT_CHECK;
                    end else begin
                        n_switch  = 1'b0;
                        n_mode    = MODE_DAYLIGHT_WAIT;
                        wait_code = WAIT_DAYLIGHT;
                    end
                end
                default: begin
                    n_switch  = 1'b0;
                    n_mode    = MODE_WAIT_SENSORS;
                    wait_code = WAIT_SENSOR;
                end
            endcase
        end
        // counters restart on every mode change
        if (n_mode != r_mode) begin
            n_start_cnt = '0;
            n_stop_cnt  = '0;
        end
    end

    assign o_res.panel_connect = n_switch;
    assign o_res.charge_state  = n_mode;
    assign o_res.wait_kind     = wait_code;

endmodule

`default_nettype wire
